### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the lens distortion block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, also checked across reset
`define ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### sv/ldc_pkg.sv
// ----------------------------------------------------------------------------
// ldc_pkg
// Types, constants and fixed-point helpers for the lens distortion pipeline
// ----------------------------------------------------------------------------
package ldc_pkg;

  localparam int FRAC_BITS   = 27;
  localparam int ITERATIONS  = 8;
  localparam int DATA_W      = 32;
  localparam int WIDE_W      = 2 * DATA_W;
  localparam int SUM_W       = 40;
  localparam int QUO_W       = DATA_W + 1;
  localparam int CFG_INDEX_W = 3;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  localparam q_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // what an item asks of the pipeline
  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_OFFSET,
    MODE_CLOSED,
    MODE_ITER
  } mode_t;

  // register indexes on the config port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_K1,
    REG_K2,
    REG_P1,
    REG_P2,
    REG_BYPASS,
    REG_METHOD
  } cfg_reg_t;

  typedef struct packed {
    q_t k1;
    q_t k2;
    q_t p1;
    q_t p2;
  } coef_t;

  // one point in flight with its working values
  typedef struct packed {
    mode_t mode;
    q_t    x;
    q_t    y;
    q_t    ux;
    q_t    uy;
    q_t    dx;
    q_t    dy;
    q_t    ka;
    q_t    kb;
    logic  flag;
  } item_t;

  // saturated value with its overflow mark
  typedef struct packed {
    q_t   v;
    logic f;
  } satq_t;

  function automatic satq_t sat_wide(input wide_t v);
    satq_t r;
    r.f = 1'b0;
    r.v = q_t'(v[DATA_W-1:0]);
    if (v > wide_t'(Q_MAX)) begin
      r.f = 1'b1;
      r.v = Q_MAX;
    end else if (v < wide_t'(Q_MIN)) begin
      r.f = 1'b1;
      r.v = Q_MIN;
    end
    return r;
  endfunction

  function automatic satq_t sat_sum(input sum_t v);
    return sat_wide(wide_t'(v));
  endfunction

  // product with round half up, floor shift and saturation
  function automatic satq_t qmul(input q_t a, input q_t b);
    wide_t                          p;
    logic signed [WIDE_W-FRAC_BITS-1:0] s;
    p = wide_t'(a) * wide_t'(b) + (wide_t'(1) <<< (FRAC_BITS - 1));
    s = p[WIDE_W-1:FRAC_BITS];
    return sat_wide(wide_t'(s));
  endfunction

  function automatic satq_t qsub(input q_t a, input q_t b);
    return sat_sum(sum_t'(a) - sum_t'(b));
  endfunction

endpackage

### sv/ldc_offset.sv
// ----------------------------------------------------------------------------
// ldc_offset
// Eight-stage radial-tangential offset of the current estimate, then update
// ----------------------------------------------------------------------------
module ldc_offset (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  logic          first,
  input  ldc_pkg::coef_t coef,
  input  logic          in_valid,
  input  ldc_pkg::item_t in_item,
  output logic          out_valid,
  output ldc_pkg::item_t out_item
);

  localparam int STAGES = 8;

  logic [STAGES-1:0] vld;
  ldc_pkg::item_t    it [STAGES];

  ldc_pkg::satq_t s1_x2, s1_y2, s1_xy;
  ldc_pkg::satq_t s2_r2, s2_fx, s2_fy;
  ldc_pkg::q_t    s2_xy;
  logic           s2_f;
  ldc_pkg::satq_t s3_r4, s3_ka, s3_pa, s3_pb, s3_tx, s3_ty;
  logic           s3_f;
  ldc_pkg::satq_t s4_kb;
  ldc_pkg::q_t    s4_ka, s4_pa, s4_pb, s4_tx, s4_ty;
  logic           s4_f;
  ldc_pkg::satq_t s5_rad;
  ldc_pkg::q_t    s5_ka, s5_kb, s5_pa, s5_pb, s5_tx, s5_ty;
  logic           s5_f;
  ldc_pkg::satq_t s6_mx, s6_my;
  ldc_pkg::q_t    s6_ka, s6_kb, s6_pa, s6_pb, s6_tx, s6_ty;
  logic           s6_f;
  ldc_pkg::satq_t s7_dx, s7_dy;
  ldc_pkg::q_t    s7_ka, s7_kb;
  logic           s7_f;

  ldc_pkg::satq_t r2_c, fx_c, fy_c;
  ldc_pkg::item_t upd_item;

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  // squared radius and tangential factors
  always_comb begin
    r2_c = ldc_pkg::sat_sum(ldc_pkg::sum_t'(s1_x2.v) + ldc_pkg::sum_t'(s1_y2.v));
    fx_c = ldc_pkg::sat_sum(ldc_pkg::sum_t'(r2_c.v) + (ldc_pkg::sum_t'(s1_x2.v) <<< 1));
    fy_c = ldc_pkg::sat_sum(ldc_pkg::sum_t'(r2_c.v) + (ldc_pkg::sum_t'(s1_y2.v) <<< 1));
  end

  // final stage: fold the offset into the item according to its mode
  always_comb begin
    ldc_pkg::satq_t sx;
    ldc_pkg::satq_t sy;
    logic           of;
    upd_item = it[STAGES-2];
    of = s7_f | s7_dx.f | s7_dy.f;
    sx = ldc_pkg::qsub(upd_item.x, s7_dx.v);
    sy = ldc_pkg::qsub(upd_item.y, s7_dy.v);
    unique case (upd_item.mode)
      ldc_pkg::MODE_ITER: begin
        upd_item.ux   = sx.v;
        upd_item.uy   = sy.v;
        upd_item.flag = upd_item.flag | of | sx.f | sy.f;
      end
      ldc_pkg::MODE_OFFSET: begin
        if (first) begin
          upd_item.ux   = s7_dx.v;
          upd_item.uy   = s7_dy.v;
          upd_item.flag = upd_item.flag | of;
        end
      end
      ldc_pkg::MODE_CLOSED: begin
        if (first) begin
          upd_item.dx   = s7_dx.v;
          upd_item.dy   = s7_dy.v;
          upd_item.ka   = s7_ka;
          upd_item.kb   = s7_kb;
          upd_item.flag = upd_item.flag | of;
        end
      end
      ldc_pkg::MODE_PASS: begin
      end
    endcase
  end

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (ce) begin
      // products of the point
      it[0] <= in_item;
      s1_x2 <= ldc_pkg::qmul(in_item.ux, in_item.ux);
      s1_y2 <= ldc_pkg::qmul(in_item.uy, in_item.uy);
      s1_xy <= ldc_pkg::qmul(in_item.ux, in_item.uy);
      // radius sums
      it[1] <= it[0];
      s2_r2 <= r2_c;
      s2_fx <= fx_c;
      s2_fy <= fy_c;
      s2_xy <= s1_xy.v;
      s2_f  <= s1_x2.f | s1_y2.f | s1_xy.f;
      // coefficient products
      it[2] <= it[1];
      s3_r4 <= ldc_pkg::qmul(s2_r2.v, s2_r2.v);
      s3_ka <= ldc_pkg::qmul(coef.k1, s2_r2.v);
      s3_pa <= ldc_pkg::qmul(coef.p1, s2_xy);
      s3_pb <= ldc_pkg::qmul(coef.p2, s2_xy);
      s3_tx <= ldc_pkg::qmul(coef.p2, s2_fx.v);
      s3_ty <= ldc_pkg::qmul(coef.p1, s2_fy.v);
      s3_f  <= s2_f | s2_r2.f | s2_fx.f | s2_fy.f;
      // fourth-power term
      it[3] <= it[2];
      s4_kb <= ldc_pkg::qmul(coef.k2, s3_r4.v);
      s4_ka <= s3_ka.v;
      s4_pa <= s3_pa.v;
      s4_pb <= s3_pb.v;
      s4_tx <= s3_tx.v;
      s4_ty <= s3_ty.v;
      s4_f  <= s3_f | s3_r4.f | s3_ka.f | s3_pa.f | s3_pb.f | s3_tx.f | s3_ty.f;
      // radial factor
      it[4]  <= it[3];
      s5_rad <= ldc_pkg::sat_sum(ldc_pkg::sum_t'(s4_ka) + ldc_pkg::sum_t'(s4_kb.v));
      s5_ka  <= s4_ka;
      s5_kb  <= s4_kb.v;
      s5_pa  <= s4_pa;
      s5_pb  <= s4_pb;
      s5_tx  <= s4_tx;
      s5_ty  <= s4_ty;
      s5_f   <= s4_f | s4_kb.f;
      // radial offsets
      it[5] <= it[4];
      s6_mx <= ldc_pkg::qmul(it[4].ux, s5_rad.v);
      s6_my <= ldc_pkg::qmul(it[4].uy, s5_rad.v);
      s6_ka <= s5_ka;
      s6_kb <= s5_kb;
      s6_pa <= s5_pa;
      s6_pb <= s5_pb;
      s6_tx <= s5_tx;
      s6_ty <= s5_ty;
      s6_f  <= s5_f | s5_rad.f;
      // total offset
      it[6] <= it[5];
      s7_dx <= ldc_pkg::sat_sum(ldc_pkg::sum_t'(s6_mx.v) + (ldc_pkg::sum_t'(s6_pa) <<< 1)
                                + ldc_pkg::sum_t'(s6_tx));
      s7_dy <= ldc_pkg::sat_sum(ldc_pkg::sum_t'(s6_my.v) + (ldc_pkg::sum_t'(s6_pb) <<< 1)
                                + ldc_pkg::sum_t'(s6_ty));
      s7_ka <= s6_ka;
      s7_kb <= s6_kb;
      s7_f  <= s6_f | s6_mx.f | s6_my.f;
      // update
      it[7] <= upd_item;
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_item  = it[STAGES-1];

endmodule

### sv/ldc_inverse.sv
// ----------------------------------------------------------------------------
// ldc_inverse
// Closed-form inverse: denominator, pipelined restoring divide, subtraction
// ----------------------------------------------------------------------------
module ldc_inverse (
  input  logic          clk,
  input  logic          rst,
  input  logic          ce,
  input  ldc_pkg::coef_t coef,
  input  logic          in_valid,
  input  ldc_pkg::item_t in_item,
  output logic          out_valid,
  output ldc_pkg::item_t out_item
);

  localparam int QW     = ldc_pkg::QUO_W;
  localparam int DW     = ldc_pkg::DATA_W;
  localparam int SHIFT  = QW - ldc_pkg::FRAC_BITS;
  localparam int POST   = QW + 3;
  localparam int SUB    = POST + 1;
  localparam int STAGES = SUB + 1;

  localparam logic [QW-1:0] LIM_NEG = QW'(1) << (DW - 1);
  localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);

  typedef struct packed {
    logic          neg;
    logic          num_neg;
    logic          num_zero;
    logic          zero;
    logic          ovf;
    logic [DW-1:0] n;
    logic [DW-1:0] d;
    logic [QW-1:0] rem;
    logic [QW-1:0] q;
  } lane_t;

  logic [STAGES-1:0] vld;
  ldc_pkg::item_t    it [STAGES];
  lane_t             ln [QW+1][2];

  ldc_pkg::satq_t d1_c, d1_e;
  ldc_pkg::q_t    d2_den;

  ldc_pkg::item_t d2_item, post_item, sub_item;
  ldc_pkg::satq_t den_c;
  lane_t          prep [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  // denominator sum
  always_comb begin
    logic closed;
    closed  = (it[0].mode == ldc_pkg::MODE_CLOSED);
    den_c   = ldc_pkg::sat_sum((ldc_pkg::sum_t'(1) <<< ldc_pkg::FRAC_BITS)
                + (ldc_pkg::sum_t'(it[0].ka) <<< 2)
                + (ldc_pkg::sum_t'(it[0].kb) <<< 2) + (ldc_pkg::sum_t'(it[0].kb) <<< 1)
                + (ldc_pkg::sum_t'(d1_c.v) <<< 3) + (ldc_pkg::sum_t'(d1_e.v) <<< 3));
    d2_item = it[0];
    d2_item.flag = it[0].flag | (closed & (d1_c.f | d1_e.f | den_c.f));
  end

  // magnitudes, zero and overflow checks
  always_comb begin
    ldc_pkg::q_t num;
    for (int j = 0; j < 2; j++) begin
      num = (j == 0) ? it[1].dx : it[1].dy;
      prep[j].num_neg  = num[DW-1];
      prep[j].num_zero = (num == '0);
      prep[j].neg      = num[DW-1] ^ d2_den[DW-1];
      prep[j].n        = num[DW-1] ? DW'(-num) : DW'(num);
      prep[j].d        = d2_den[DW-1] ? DW'(-d2_den) : DW'(d2_den);
      prep[j].zero     = (d2_den == '0);
      prep[j].rem      = QW'(prep[j].n >> SHIFT);
      prep[j].ovf      = (prep[j].rem >= {1'b0, prep[j].d});
      prep[j].q        = '0;
    end
  end

  // quotient sign and saturation
  always_comb begin
    ldc_pkg::satq_t qs [2];
    lane_t          l;
    post_item = it[POST-1];
    for (int j = 0; j < 2; j++) begin
      l = ln[QW][j];
      qs[j].f = 1'b0;
      qs[j].v = ldc_pkg::q_t'(l.q[DW-1:0]);
      if (l.zero) begin
        qs[j].f = 1'b1;
        qs[j].v = l.num_zero ? '0 : (l.num_neg ? ldc_pkg::Q_MIN : ldc_pkg::Q_MAX);
      end else if (l.ovf) begin
        qs[j].f = 1'b1;
        qs[j].v = l.neg ? ldc_pkg::Q_MIN : ldc_pkg::Q_MAX;
      end else if (l.neg) begin
        if (l.q > LIM_NEG) begin
          qs[j].f = 1'b1;
          qs[j].v = ldc_pkg::Q_MIN;
        end else begin
          qs[j].v = ldc_pkg::q_t'(DW'(QW'(0) - l.q));
        end
      end else if (l.q > LIM_POS) begin
        qs[j].f = 1'b1;
        qs[j].v = ldc_pkg::Q_MAX;
      end
    end
    if (post_item.mode == ldc_pkg::MODE_CLOSED) begin
      post_item.dx   = qs[0].v;
      post_item.dy   = qs[1].v;
      post_item.flag = post_item.flag | qs[0].f | qs[1].f;
    end
  end

  // point minus quotient
  always_comb begin
    ldc_pkg::satq_t sx;
    ldc_pkg::satq_t sy;
    sub_item = it[POST];
    sx = ldc_pkg::qsub(sub_item.x, sub_item.dx);
    sy = ldc_pkg::qsub(sub_item.y, sub_item.dy);
    if (sub_item.mode == ldc_pkg::MODE_CLOSED) begin
      sub_item.ux   = sx.v;
      sub_item.uy   = sy.v;
      sub_item.flag = sub_item.flag | sx.f | sy.f;
    end
  end

  // item carriers and the non-divider stages
  always_ff @(posedge clk) begin
    if (ce) begin
      it[0]  <= in_item;
      d1_c   <= ldc_pkg::qmul(coef.p1, in_item.y);
      d1_e   <= ldc_pkg::qmul(coef.p2, in_item.x);
      it[1]  <= d2_item;
      d2_den <= den_c.v;
      for (int s = 2; s < POST; s++) begin
        it[s] <= it[s-1];
      end
      it[POST] <= post_item;
      it[SUB]  <= sub_item;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int j = 0; j < 2; j++) begin
        ln[0][j] <= prep[j];
      end
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_bit
    localparam int BIT = QW - 1 - k;
    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic          bin;
      logic [QW-1:0] t;
      lane_t         nxt;
      if (BIT >= ldc_pkg::FRAC_BITS) begin : g_num
        assign bin = ln[k][j].n[BIT-ldc_pkg::FRAC_BITS];
      end else begin : g_zero
        assign bin = 1'b0;
      end
      assign t = {ln[k][j].rem[QW-2:0], bin};
      // restoring step
      always_comb begin
        nxt = ln[k][j];
        if (t >= {1'b0, ln[k][j].d}) begin
          nxt.rem    = t - {1'b0, ln[k][j].d};
          nxt.q[BIT] = 1'b1;
        end else begin
          nxt.rem = t;
        end
      end
      always_ff @(posedge clk) begin
        if (ce) begin
          ln[k+1][j] <= nxt;
        end
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign out_item  = it[STAGES-1];

endmodule

### sv/lens_distortion_correction.sv
// Throughput: one point per clock while the output is not stalled; every method
// runs through the same pipeline, built from the 33-stage restoring divider and
// the offset stages. A stalled output holds the whole pipeline in place.
// Reset (synchronous, active high) empties the pipeline, clears the coefficients,
// sets bypass and selects the closed-form inverse.
// ----------------------------------------------------------------------------
// lens_distortion_correction
// Radial-tangential lens distortion offset and undistortion, Q4.27 stream
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lens_distortion_correction (
  input  logic                              clk,
  input  logic                              rst,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ldc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ldc_pkg::DATA_W-1:0]        cfg_data,
  // input points
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [2*ldc_pkg::DATA_W-1:0]      s_axis_tdata,  // x_in, y_in
  input  logic                              s_axis_tuser,  // opcode
  // results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [2*ldc_pkg::DATA_W-1:0]      m_axis_tdata,  // x_out, y_out
  output logic                              m_axis_tuser   // range_flag
);

  localparam int DW = ldc_pkg::DATA_W;

  ldc_pkg::coef_t coef;
  logic           bypass;
  logic           inverse_method;
  logic           ce;

  ldc_pkg::item_t in_item;
  ldc_pkg::item_t ofs_item, inv_item;
  logic           ofs_valid, inv_valid;
  ldc_pkg::item_t chain_item [ldc_pkg::ITERATIONS];
  logic           chain_valid [ldc_pkg::ITERATIONS];

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef           <= '0;
      bypass         <= 1'b1;
      inverse_method <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ldc_pkg::cfg_reg_t'(cfg_index))
        ldc_pkg::REG_K1:     coef.k1        <= cfg_data;
        ldc_pkg::REG_K2:     coef.k2        <= cfg_data;
        ldc_pkg::REG_P1:     coef.p1        <= cfg_data;
        ldc_pkg::REG_P2:     coef.p2        <= cfg_data;
        ldc_pkg::REG_BYPASS: bypass         <= cfg_data[0];
        ldc_pkg::REG_METHOD: inverse_method <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // pipeline advances unless the output word is held
  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  // incoming word
  always_comb begin
    in_item      = '0;
    in_item.x    = s_axis_tdata[DW-1:0];
    in_item.y    = s_axis_tdata[2*DW-1:DW];
    in_item.ux   = in_item.x;
    in_item.uy   = in_item.y;
    in_item.flag = 1'b0;
    if (bypass) begin
      in_item.mode = ldc_pkg::MODE_PASS;
    end else if (!s_axis_tuser) begin
      in_item.mode = ldc_pkg::MODE_OFFSET;
    end else if (inverse_method) begin
      in_item.mode = ldc_pkg::MODE_ITER;
    end else begin
      in_item.mode = ldc_pkg::MODE_CLOSED;
    end
  end

  // offset of the input point, first estimate
  ldc_offset u_ofs0 (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .first     (1'b1),
    .coef      (coef),
    .in_valid  (s_axis_tvalid && s_axis_tready),
    .in_item   (in_item),
    .out_valid (ofs_valid),
    .out_item  (ofs_item)
  );

  // closed-form inverse
  ldc_inverse u_inv (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .coef      (coef),
    .in_valid  (ofs_valid),
    .in_item   (ofs_item),
    .out_valid (inv_valid),
    .out_item  (inv_item)
  );

  assign chain_item[0]  = inv_item;
  assign chain_valid[0] = inv_valid;

  // remaining fixed-point iterations
  for (genvar i = 0; i < ldc_pkg::ITERATIONS - 1; i++) begin : g_iter
    ldc_offset u_ofs (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .first     (1'b0),
      .coef      (coef),
      .in_valid  (chain_valid[i]),
      .in_item   (chain_item[i]),
      .out_valid (chain_valid[i+1]),
      .out_item  (chain_item[i+1])
    );
  end

  assign m_axis_tvalid = chain_valid[ldc_pkg::ITERATIONS-1];
  assign m_axis_tdata  = {chain_item[ldc_pkg::ITERATIONS-1].uy,
                          chain_item[ldc_pkg::ITERATIONS-1].ux};
  assign m_axis_tuser  = chain_item[ldc_pkg::ITERATIONS-1].flag;

  // a held result word freezes the input side
  `ASSERT_IMPLY(a_stall_blocks_input, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  // reset empties the pipeline
  `ASSERT_NEXT(a_reset_empties, clk, rst, !m_axis_tvalid)

endmodule

### bench/tb_lens_distortion_correction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lens_distortion_correction
// Checks offset, closed-form and iterative undistortion and bypass against a
// fixed-point predictor, under random source gaps and sink stalls
// ----------------------------------------------------------------------------
module tb_lens_distortion_correction;

  localparam int LATENCY   = 102;
  localparam int MAX_CYCLE = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;  // x_in, y_in
  logic        s_axis_tuser;  // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;  // x_out, y_out
  logic        m_axis_tuser;  // range_flag

  lens_distortion_correction DUT (.*);

  // predictor copy of the registers
  longint k1, k2, p1, p2;
  bit     pass_thru, iter_mode;
  bit     ovf;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        flag;
  } point_res_t;

  point_res_t pending[$];
  int  n_mismatch;
  int  cyc;
  bit  sink_calm;
  bit  src_calm;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) begin
      ovf = 1; return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1; return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (ldc_pkg::FRAC_BITS - 1));
    return sat(p >>> ldc_pkg::FRAC_BITS);
  endfunction

  function automatic void warp(longint x, longint y, output longint dx,
                               output longint dy, output longint r2,
                               output longint r4);
    longint x2, y2, xy, rad, fx, fy;
    x2 = fmul(x, x);
    y2 = fmul(y, y);
    xy = fmul(x, y);
    r2 = sat(x2 + y2);
    r4 = fmul(r2, r2);
    rad = sat(fmul(k1, r2) + fmul(k2, r4));
    fx = sat(r2 + 2 * x2);
    fy = sat(r2 + 2 * y2);
    dx = sat(fmul(x, rad) + 2 * fmul(p1, xy) + fmul(p2, fx));
    dy = sat(fmul(y, rad) + 2 * fmul(p2, xy) + fmul(p1, fy));
  endfunction

  function automatic longint fdiv(longint num, longint den);
    bit     neg;
    longint n, d, q;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    if (d == 0) begin
      ovf = 1;
      return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
    end
    q = (n <<< ldc_pkg::FRAC_BITS) / d;
    if (neg) begin
      if (q > 64'sd2147483648) begin
        ovf = 1; return -64'sd2147483648;
      end
      return -q;
    end
    if (q > 64'sd2147483647) begin
      ovf = 1; return 64'sd2147483647;
    end
    return q;
  endfunction

  function automatic point_res_t undistort(bit op, logic [31:0] xi, logic [31:0] yi);
    point_res_t r;
    longint x, y, rx, ry, dx, dy, r2, r4, den;
    x = longint'($signed(xi));
    y = longint'($signed(yi));
    ovf = 0;
    if (pass_thru) begin
      rx = x; ry = y;
    end else if (op == 1'b0) begin
      warp(x, y, rx, ry, r2, r4);
    end else if (!iter_mode) begin
      warp(x, y, dx, dy, r2, r4);
      den = sat((64'sd1 <<< ldc_pkg::FRAC_BITS) + 4 * fmul(k1, r2) + 6 * fmul(k2, r4)
                + 8 * fmul(p1, y) + 8 * fmul(p2, x));
      rx = sat(x - fdiv(dx, den));
      ry = sat(y - fdiv(dy, den));
    end else begin
      rx = x; ry = y;
      for (int i = 0; i < ldc_pkg::ITERATIONS; i++) begin
        warp(rx, ry, dx, dy, r2, r4);
        rx = sat(x - dx);
        ry = sat(y - dy);
      end
    end
    r.x = rx[31:0];
    r.y = ry[31:0];
    r.flag = ovf;
    return r;
  endfunction

  // source side: one word, with random gaps
  task automatic send_point(bit op, logic [31:0] x, logic [31:0] y);
    int gap;
    if (!src_calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tuser  <= op;
    pending.push_back(undistort(op, x, y));
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(ldc_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ldc_pkg::REG_K1:     k1 = longint'($signed(val));
      ldc_pkg::REG_K2:     k2 = longint'($signed(val));
      ldc_pkg::REG_P1:     p1 = longint'($signed(val));
      ldc_pkg::REG_P2:     p2 = longint'($signed(val));
      ldc_pkg::REG_BYPASS: pass_thru = val[0];
      ldc_pkg::REG_METHOD: iter_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic set_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] d, bit byp, bit meth);
    write_reg(ldc_pkg::REG_K1, a);
    write_reg(ldc_pkg::REG_K2, b);
    write_reg(ldc_pkg::REG_P1, c);
    write_reg(ldc_pkg::REG_P2, d);
    write_reg(ldc_pkg::REG_BYPASS, {31'd0, byp});
    write_reg(ldc_pkg::REG_METHOD, {31'd0, meth});
    cfg_valid <= 1'b0;
  endtask

  // points mostly inside the unit disk, some anywhere
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'(int'($urandom_range(0, 1 << 28)) - (1 << 27));
      default: return 32'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return $urandom();
      default: return 32'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
    endcase
  endfunction

  task automatic test_directed_bypass();
    send_point(1'b0, 32'h7fff_ffff, 32'h8000_0000);
    send_point(1'b1, 32'h8000_0000, 32'h7fff_ffff);
    send_point(1'b0, 32'h0, 32'hffff_ffff);
    drain();
  endtask

  task automatic test_directed_edges();
    logic [31:0] ext[5];
    ext = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0800_0000, 32'hf800_0000};
    set_coefs(32'h0100_0000, 32'hff00_0000, 32'h0010_0000, 32'hfff0_0000, 0, 0);
    for (int i = 0; i < 5; i++) begin
      send_point(1'b0, ext[i], ext[4 - i]);
      send_point(1'b1, ext[i], ext[(i + 2) % 5]);
    end
    drain();
    // denominator of minus one: p2 * 8 * x outweighs the constant one
    set_coefs(32'h0, 32'h0, 32'h0, 32'hf000_0000, 0, 0);
    send_point(1'b1, 32'h0100_0000, 32'h0);
    send_point(1'b1, 32'h0, 32'h0);
    drain();
    // large k1 whose share of the denominator the p2 term cancels
    set_coefs(32'h7fff_ffff, 32'h0, 32'h0, 32'hf000_0000, 0, 0);
    send_point(1'b1, 32'h0100_0000, 32'h0100_0000);
    drain();
    set_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, 1);
    for (int i = 0; i < 5; i++) send_point(1'b1, ext[i], ext[(i + 1) % 5]);
    drain();
  endtask

  task automatic test_random(int n, bit calm);
    src_calm  = calm;
    sink_calm = calm;
    for (int i = 0; i < n; i++) send_point($urandom_range(0, 1), rand_coord(), rand_coord());
    drain();
  endtask

  // sink stalls and result checking
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (!sink_calm && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 10) - 1) @(posedge clk);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    point_res_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        e = pending.pop_front();
        if (m_axis_tdata[31:0] !== e.x || m_axis_tdata[63:32] !== e.y ||
            m_axis_tuser !== e.flag) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected x=%h y=%h flag=%b, got x=%h y=%h flag=%b",
                     e.x, e.y, e.flag, m_axis_tdata[31:0], m_axis_tdata[63:32],
                     m_axis_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > MAX_CYCLE) begin
      $display("lens_distortion_correction test failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    n_mismatch = 0;
    cyc = 0;
    sink_calm = 0;
    src_calm = 0;
    k1 = 0; k2 = 0; p1 = 0; p2 = 0;
    pass_thru = 1; iter_mode = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_bypass();
    test_directed_edges();
    for (int ph = 0; ph < 8; ph++) begin
      set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                ph == 3, ph[0]);
      test_random(130, 1'b0);
    end
    set_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), 0, 1);
    test_random(80, 1'b1);
    if (n_mismatch == 0 && pending.size() == 0) begin
      $display("lens_distortion_correction test passed");
    end else begin
      $display("lens_distortion_correction test failed");
    end
    $finish;
  end

endmodule
